// ----- design/light_gun_calibrated_aim_top_macros.svh -----
// Assertion macros for the light-gun aim block.
`ifndef LIGHT_GUN_CALIBRATED_AIM_TOP_MACROS_SVH
`define LIGHT_GUN_CALIBRATED_AIM_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every edge outside reset.
`define LGCA_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define LGCA_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LGCA_CHECK(label, clk, rst, prop, msg)
`define LGCA_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/lgca_pkg.sv -----
// Package: constants, codes and the x map for the light-gun aim block.
`default_nettype none

package lgca_pkg;

  // calibration
  localparam int SAMPLES = 10;
  localparam int CNT_W   = 6;
  localparam int SUM_W   = 16;
  localparam logic [CNT_W-1:0] SAMPLE_CNT = CNT_W'(SAMPLES);

  // division by SAMPLES: ceiling reciprocal, exact for every SUM_W-bit sum
  localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W   = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << DIV_SHIFT) + longint'(SAMPLES) - 1) / longint'(SAMPLES));

  // screen geometry
  localparam logic [SUM_W-1:0] CENTRE_X    = SUM_W'(160);
  localparam logic [SUM_W-1:0] CENTRE_Y    = SUM_W'(112);
  localparam logic [11:0]      HALF_SPRITE = 12'd8;

  // piecewise x map bounds
  localparam logic [7:0] MAP_A_LO   = 8'd60;
  localparam logic [7:0] MAP_A_HI   = 8'd182;
  localparam logic [7:0] MAP_B_LO   = 8'd229;
  localparam logic [7:0] MAP_B_BIAS = 8'd106;
  localparam logic [7:0] MAP_C_BIAS = 8'd150;

  // item kinds
  localparam logic REQ_BUTTON = 1'b0;
  localparam logic REQ_FRAME  = 1'b1;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_MAP    = 2'd1,
    MODE_OFFSET = 2'd2
  } mode_t;

  // raw x (9-bit signed) to screen x; offscreen and the gap give 0
  function automatic logic [8:0] map_x(input logic [8:0] x);
    logic [7:0] v;
    logic [7:0] t;
    v = x[7:0];
    t = '0;
    if (!x[8]) begin
      if (v >= MAP_A_LO && v <= MAP_A_HI) begin
        t = v - MAP_A_LO;
      end else if (v >= MAP_B_LO) begin
        t = v - MAP_B_BIAS;
      end else if (v < MAP_A_LO) begin
        t = v + MAP_C_BIAS;
      end
    end
    return {t, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ----- design/lgca_if.sv -----
// Interfaces: request and result channels of the light-gun aim block.
`default_nettype none

interface lgca_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic              trigger_pressed;
  logic              calib_pressed;
  logic              mode_pressed;
  logic signed [8:0] raw_x;
  logic signed [8:0] raw_y;

  modport source (
    output valid, req_type, trigger_pressed, calib_pressed, mode_pressed, raw_x, raw_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, trigger_pressed, calib_pressed, mode_pressed, raw_x, raw_y,
    output ready
  );
endinterface

interface lgca_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] cross_x;
  logic signed [9:0]  cross_y;
  logic        [1:0]  view_mode;
  logic               calibrating;
  logic signed [9:0]  off_x;
  logic signed [8:0]  off_y;
  logic        [5:0]  samples_taken;

  modport source (
    output valid, cross_x, cross_y, view_mode, calibrating, off_x, off_y, samples_taken,
    input  ready
  );
  modport sink (
    input  valid, cross_x, cross_y, view_mode, calibrating, off_x, off_y, samples_taken,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/light_gun_calibrated_aim_top.sv -----
// Top level: light-gun aim with calibration, one item in, one result out.
//
//   channel | dir | handshake   | carries
//   --------+-----+-------------+---------------------------------------------
//   req     | in  | valid/ready | item kind, three buttons, raw x and y
//   res     | out | valid/ready | crosshair, mode, calibration state, offsets
//
// One item per cycle unless a result is stalled; each result appears the cycle
// after its item is taken. The whole update (x map, accumulate, divide by SAMPLES
// via a reciprocal multiply per axis, crosshair add) sits between the inputs and
// the state registers, which also serve as the result register.
// req.ready is low only while a result waits and res.ready is low.
// rst (synchronous) restores the power-on state: crosshair at 152,104.
`default_nettype none

`include "light_gun_calibrated_aim_top_macros.svh"

module light_gun_calibrated_aim_top
  import lgca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lgca_in_if.sink    req,
  lgca_out_if.source res
);

  // state; also the payload of the pending result
  mode_t                    mode_reg, mode_reg_next;
  logic                     calib_flag, calib_flag_next;
  logic [CNT_W-1:0]         sample_count, sample_count_next;
  logic [SUM_W-1:0]         sum_x, sum_x_next;
  logic [SUM_W-1:0]         sum_y, sum_y_next;
  logic [9:0]               offset_x, offset_x_next;
  logic [8:0]               offset_y, offset_y_next;
  logic [10:0]              pos_x, pos_x_next;
  logic [9:0]               pos_y, pos_y_next;
  logic                     res_valid;

  logic                     can_take;
  logic                     take_item;
  logic [8:0]               mapped;
  logic                     sample_ok;
  logic [SUM_W-1:0]         sum_x_add, sum_y_add;
  logic [CNT_W-1:0]         cnt_after;
  logic [SUM_W-1:0]         sum_x_sel, sum_y_sel;
  logic [SUM_W+RECIP_W-1:0] prod_x, prod_y;
  logic [SUM_W-1:0]         quo_x, quo_y;
  logic [SUM_W-1:0]         diff_x, diff_y;
  logic [11:0]              rx_ext, map_ext, offx_ext, fx_raw, fx_map, fx_off;
  logic [10:0]              ry_ext, offy_ext, fy_raw, fy_off;

  // a new item goes in unless a result is stuck at the output
  assign can_take  = !res_valid || res.ready;
  assign req.ready = can_take;
  assign take_item = req.valid && can_take;

  // x map and one calibration sample
  assign mapped    = map_x(req.raw_x);
  assign sample_ok = req.trigger_pressed && calib_flag && (sample_count < SAMPLE_CNT)
                     && !req.raw_x[8] && !req.raw_y[8];
  assign sum_x_add = sum_x + SUM_W'(mapped);
  assign sum_y_add = sum_y + SUM_W'(req.raw_y[7:0]);
  assign sum_x_sel = sample_ok ? sum_x_add : sum_x;
  assign sum_y_sel = sample_ok ? sum_y_add : sum_y;
  assign cnt_after = sample_ok ? sample_count + CNT_W'(1) : sample_count;

  // truncated average: multiply by the ceiling reciprocal, keep the top part
  assign prod_x = (SUM_W+RECIP_W)'(sum_x_sel) * (SUM_W+RECIP_W)'(RECIP);
  assign prod_y = (SUM_W+RECIP_W)'(sum_y_sel) * (SUM_W+RECIP_W)'(RECIP);
  assign quo_x  = SUM_W'(prod_x >> DIV_SHIFT);
  assign quo_y  = SUM_W'(prod_y >> DIV_SHIFT);
  assign diff_x = CENTRE_X - quo_x;
  assign diff_y = CENTRE_Y - quo_y;

  // crosshair candidates, wide enough before wrapping to the field width
  assign rx_ext   = {{3{req.raw_x[8]}}, req.raw_x};
  assign map_ext  = {3'b000, mapped};
  assign offx_ext = {{2{offset_x[9]}}, offset_x};
  assign fx_raw   = rx_ext - HALF_SPRITE;
  assign fx_map   = map_ext - HALF_SPRITE;
  assign fx_off   = map_ext + offx_ext - HALF_SPRITE;
  assign ry_ext   = {{2{req.raw_y[8]}}, req.raw_y};
  assign offy_ext = {{2{offset_y[8]}}, offset_y};
  assign fy_raw   = ry_ext - HALF_SPRITE[10:0];
  assign fy_off   = ry_ext + offy_ext - HALF_SPRITE[10:0];

  always_comb begin
    mode_reg_next     = mode_reg;
    calib_flag_next   = calib_flag;
    sample_count_next = sample_count;
    sum_x_next        = sum_x;
    sum_y_next        = sum_y;
    offset_x_next     = offset_x;
    offset_y_next     = offset_y;
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;

    if (req.req_type == REQ_BUTTON) begin
      // trigger first, then calibration start, then mode
      if (req.trigger_pressed && calib_flag) begin
        sum_x_next        = sum_x_sel;
        sum_y_next        = sum_y_sel;
        sample_count_next = cnt_after;
        if (cnt_after == SAMPLE_CNT) begin
          offset_x_next     = diff_x[9:0];
          offset_y_next     = diff_y[8:0];
          sample_count_next = '0;
          calib_flag_next   = 1'b0;
        end
      end
      if (req.calib_pressed) begin
        sample_count_next = '0;
        sum_x_next        = '0;
        sum_y_next        = '0;
        calib_flag_next   = 1'b1;
      end
      if (req.mode_pressed) begin
        case (mode_reg)
          MODE_RAW: mode_reg_next = MODE_MAP;
          MODE_MAP: mode_reg_next = MODE_OFFSET;
          default:  mode_reg_next = MODE_RAW;
        endcase
      end
    end else begin
      case (mode_reg)
        MODE_RAW: begin
          pos_x_next = fx_raw[10:0];
          pos_y_next = fy_raw[9:0];
        end
        MODE_MAP: begin
          pos_x_next = fx_map[10:0];
          pos_y_next = fy_raw[9:0];
        end
        MODE_OFFSET: begin
          pos_x_next = fx_off[10:0];
          pos_y_next = fy_off[9:0];
        end
        default: begin
          pos_x_next = pos_x;
          pos_y_next = pos_y;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_RAW;
      calib_flag   <= 1'b0;
      sample_count <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      pos_x        <= 11'd152;
      pos_y        <= 10'd104;
      res_valid    <= 1'b0;
    end else begin
      if (take_item) begin
        mode_reg     <= mode_reg_next;
        calib_flag   <= calib_flag_next;
        sample_count <= sample_count_next;
        sum_x        <= sum_x_next;
        sum_y        <= sum_y_next;
        offset_x     <= offset_x_next;
        offset_y     <= offset_y_next;
        pos_x        <= pos_x_next;
        pos_y        <= pos_y_next;
        res_valid    <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // state only moves on a taken item, so it holds steady under a stalled result
  assign res.valid         = res_valid;
  assign res.cross_x       = pos_x;
  assign res.cross_y       = pos_y;
  assign res.view_mode     = mode_reg;
  assign res.calibrating   = calib_flag;
  assign res.off_x         = offset_x;
  assign res.off_y         = offset_y;
  assign res.samples_taken = sample_count;

  `LGCA_CHECK(a_cnt_bound, clk, rst, sample_count < SAMPLE_CNT, "sample count at limit")
  `LGCA_CHECK(a_idle_cnt, clk, rst, calib_flag || sample_count == '0, "count while idle")
  `LGCA_NEXT(a_res_follows, clk, rst, take_item, res_valid, "taken item gave no result")
  `LGCA_CHECK(a_no_overrun, clk, rst, !(res_valid && !res.ready && take_item), "result overrun")

endmodule

`default_nettype wire

// ----- tb/sv/light_gun_calibrated_aim_top_test.sv -----
// Testbench for the light-gun aim block: directed and random items checked against a local model.
module light_gun_calibrated_aim_top_test;
  import lgca_pkg::*;

  // screen geometry used by the local model
  localparam int AIM_CENTRE_X = 160;
  localparam int AIM_CENTRE_Y = 112;
  localparam int AIM_HALF     = 8;
  localparam logic signed [8:0] OFFSCREEN = -9'sd1;

  // run shape
  localparam int RANDOM_ITEMS   = 700;
  localparam int HOLD_ITEMS     = 30;
  localparam int FLAT_ITEMS     = 120;
  localparam int HOLD_CYCLES    = 48;
  localparam int TAIL_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // one request item as driven on the input channel
  typedef struct packed {
    logic              kind;
    logic              trig;
    logic              calib;
    logic              mode;
    logic signed [8:0] x;
    logic signed [8:0] y;
  } aim_item_t;

  // one result item, field for field as on the output channel
  typedef struct packed {
    logic signed [10:0] cross_x;
    logic signed [9:0]  cross_y;
    logic        [1:0]  view_mode;
    logic               calibrating;
    logic signed [9:0]  off_x;
    logic signed [8:0]  off_y;
    logic        [5:0]  samples_taken;
  } aim_view_t;

  logic clk = 1'b0;
  logic rst;

  lgca_in_if  req_ch ();
  lgca_out_if res_ch ();

  light_gun_calibrated_aim_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local model of the aim block: its own copy of the state
  // ---------------------------------------------------------------------------
  mode_t              aim_mode;
  logic               calib_on;
  logic        [5:0]  sample_cnt;
  logic        [15:0] acc_x;
  logic        [15:0] acc_y;
  logic signed [9:0]  ofs_x;
  logic signed [8:0]  ofs_y;
  logic signed [10:0] aim_x;
  logic signed [9:0]  aim_y;

  aim_view_t   pending_views[$];
  int unsigned bad_results  = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  bit          send_gaps    = 1'b1;
  bit          take_gaps    = 1'b1;

  // raw x to screen x; offscreen and the gap between the two bands give 0
  function automatic int screen_x(input logic signed [8:0] x);
    int v;
    v = x;
    if (v >= 60 && v <= 182) begin
      return (v - 60) * 2;
    end
    if (v >= 229 && v <= 255) begin
      return (v - 106) * 2;
    end
    if (v >= 0 && v <= 59) begin
      return (v + 150) * 2;
    end
    return 0;
  endfunction

  function automatic void reset_aim();
    aim_mode   = MODE_RAW;
    calib_on   = 1'b0;
    sample_cnt = '0;
    acc_x      = '0;
    acc_y      = '0;
    ofs_x      = '0;
    ofs_y      = '0;
    aim_x      = 11'sd152;
    aim_y      = 10'sd104;
  endfunction

  // applies one item to the model and returns the result it should produce
  function automatic aim_view_t advance_aim(input aim_item_t it);
    int px;
    int py;
    px = aim_x;
    py = aim_y;
    if (it.kind == REQ_BUTTON) begin
      // order matters: trigger first, then calibration start, then mode
      if (it.trig && calib_on) begin
        // offscreen readings take no sample
        if (sample_cnt < SAMPLES && $signed(it.x) >= 0 && $signed(it.y) >= 0) begin
          acc_x      = acc_x + 16'(screen_x(it.x));
          acc_y      = acc_y + 16'($signed(it.y));
          sample_cnt = sample_cnt + 6'd1;
        end
        if (sample_cnt == SAMPLES) begin
          // truncated average, offset taken from the screen centre
          ofs_x      = 10'(AIM_CENTRE_X - int'(acc_x / SAMPLES));
          ofs_y      = 9'(AIM_CENTRE_Y - int'(acc_y / SAMPLES));
          sample_cnt = '0;
          calib_on   = 1'b0;
        end
      end
      // restart clears the count and both sums, also mid-calibration
      if (it.calib) begin
        sample_cnt = '0;
        acc_x      = '0;
        acc_y      = '0;
        calib_on   = 1'b1;
      end
      if (it.mode) begin
        aim_mode = (aim_mode == MODE_OFFSET) ? MODE_RAW : mode_t'(aim_mode + 2'd1);
      end
    end else begin
      case (aim_mode)
        MODE_RAW: begin
          px = $signed(it.x) - AIM_HALF;
          py = $signed(it.y) - AIM_HALF;
        end
        MODE_MAP: begin
          px = screen_x(it.x) - AIM_HALF;
          py = $signed(it.y) - AIM_HALF;
        end
        MODE_OFFSET: begin
          px = screen_x(it.x) + ofs_x - AIM_HALF;
          py = $signed(it.y) + ofs_y - AIM_HALF;
        end
        default: begin
        end
      endcase
      aim_x = 11'(px);
      aim_y = 10'(py);
    end
    return '{aim_x, aim_y, aim_mode, calib_on, ofs_x, ofs_y, sample_cnt};
  endfunction

  function automatic string show_view(input aim_view_t v);
    return $sformatf("cross %0d,%0d mode %0d cal %0b off %0d,%0d samples %0d",
                     v.cross_x, v.cross_y, v.view_mode, v.calibrating,
                     v.off_x, v.off_y, v.samples_taken);
  endfunction

  function automatic void note_failure(input string msg);
    bad_results++;
    if (bad_results <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: results compared first, then the item taken at this edge is
  // predicted; a result never belongs to an item taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    aim_view_t got;
    aim_view_t want;
    if (rst) begin
      reset_aim();
      pending_views.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.cross_x, res_ch.cross_y, res_ch.view_mode, res_ch.calibrating,
                res_ch.off_x, res_ch.off_y, res_ch.samples_taken};
        if (pending_views.size() == 0) begin
          note_failure({"result with nothing expected: ", show_view(got)});
        end else begin
          want = pending_views.pop_front();
          if (got !== want) begin
            note_failure({"got ", show_view(got), " / expected ", show_view(want)});
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pending_views.push_back(advance_aim('{req_ch.req_type, req_ch.trigger_pressed,
                                              req_ch.calib_pressed, req_ch.mode_pressed,
                                              req_ch.raw_x, req_ch.raw_y}));
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("light_gun_calibrated_aim_top_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus a long hold-off when a test asks for one
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (take_gaps && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders and coordinate choices
  // ---------------------------------------------------------------------------
  function automatic aim_item_t button_item(input logic trig, input logic calib,
                                            input logic mode, input logic signed [8:0] x,
                                            input logic signed [8:0] y);
    return '{REQ_BUTTON, trig, calib, mode, x, y};
  endfunction

  // button fields are ignored on frames, so they carry noise
  function automatic aim_item_t frame_item(input logic signed [8:0] x,
                                           input logic signed [8:0] y);
    return '{REQ_FRAME, 1'($urandom), 1'($urandom), 1'($urandom), x, y};
  endfunction

  // band edges of the x map
  function automatic logic signed [8:0] edge_coord(input int k);
    case (k)
      0:       return 9'sd0;
      1:       return 9'sd59;
      2:       return 9'sd60;
      3:       return 9'sd182;
      4:       return 9'sd183;
      5:       return 9'sd228;
      6:       return 9'sd229;
      default: return 9'sd255;
    endcase
  endfunction

  function automatic logic signed [8:0] seen_coord();
    if ($urandom_range(0, 5) == 0) begin
      return edge_coord($urandom_range(0, 7));
    end
    return 9'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [8:0] any_coord();
    if ($urandom_range(0, 7) == 0) begin
      return OFFSCREEN;
    end
    return seen_coord();
  endfunction

  // drives one item and waits for it to be taken; valid stays high into the
  // next call unless a gap is drawn
  task automatic offer_item(input aim_item_t it);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= it.kind;
    req_ch.trigger_pressed <= it.trig;
    req_ch.calib_pressed   <= it.calib;
    req_ch.mode_pressed    <= it.mode;
    req_ch.raw_x           <= it.x;
    req_ch.raw_y           <= it.y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // a calibration pass with random content: mostly good triggers, some
  // offscreen ones, frames, restarts and mode presses mixed in
  task automatic calib_burst();
    int unsigned steps;
    int unsigned pick;
    offer_item(button_item(1'($urandom), 1'b1, 1'($urandom_range(0, 5) == 0),
                           any_coord(), any_coord()));
    steps = $urandom_range(SAMPLES - 2, SAMPLES + 4);
    repeat (steps) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        offer_item(button_item(1'b1, 1'b0, 1'b0, seen_coord(), seen_coord()));
      end else if (pick < 16) begin
        if ($urandom_range(0, 1) == 0) begin
          offer_item(button_item(1'b1, 1'b0, 1'($urandom), OFFSCREEN, seen_coord()));
        end else begin
          offer_item(button_item(1'b1, 1'b0, 1'($urandom), seen_coord(), OFFSCREEN));
        end
      end else if (pick < 18) begin
        offer_item(frame_item(any_coord(), any_coord()));
      end else if (pick < 19) begin
        offer_item(button_item(1'b1, 1'b1, 1'b0, seen_coord(), seen_coord()));
      end else begin
        offer_item(button_item(1'b0, 1'b0, 1'b1, any_coord(), any_coord()));
      end
    end
  endtask

  // random mix up to a total item count
  task automatic run_mix(input int unsigned target);
    int unsigned pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        calib_burst();
      end else if (pick < 8) begin
        // change mode then watch the crosshair move
        offer_item(button_item(1'b0, 1'b0, 1'b1, any_coord(), any_coord()));
        repeat ($urandom_range(2, 6)) offer_item(frame_item(any_coord(), any_coord()));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer_item('{1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       any_coord(), any_coord()});
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // raw mode at both extremes, offscreen gives -9
  task automatic test_raw_frames();
    offer_item(frame_item(OFFSCREEN, OFFSCREEN));
    offer_item(frame_item(9'sd255, 9'sd255));
  endtask

  // mapped mode across every band edge and the offscreen value
  task automatic test_mapped_frames();
    offer_item(button_item(1'b0, 1'b0, 1'b1, 9'sd0, 9'sd0));
    for (int k = 0; k < 8; k++) begin
      offer_item(frame_item(edge_coord(k), edge_coord(7 - k)));
    end
    offer_item(frame_item(OFFSCREEN, 9'sd0));
  endtask

  // trigger while idle, restart after a sample, offscreen triggers, a frame
  // with the trigger held, and a run to the largest offsets
  task automatic test_calibration();
    offer_item(button_item(1'b1, 1'b1, 1'b0, 9'sd10, 9'sd10));
    offer_item(button_item(1'b1, 1'b1, 1'b0, 9'sd100, 9'sd50));
    repeat (4) offer_item(button_item(1'b1, 1'b0, 1'b0, 9'sd59, 9'sd255));
    offer_item(button_item(1'b1, 1'b0, 1'b0, OFFSCREEN, 9'sd255));
    offer_item(button_item(1'b1, 1'b0, 1'b0, 9'sd59, OFFSCREEN));
    offer_item('{REQ_FRAME, 1'b1, 1'b1, 1'b0, 9'sd59, 9'sd255});
    repeat (6) offer_item(button_item(1'b1, 1'b0, 1'b0, 9'sd59, 9'sd255));
    // calibration has ended: this trigger changes nothing
    offer_item(button_item(1'b1, 1'b0, 1'b0, 9'sd59, 9'sd255));
  endtask

  // offset mode with the extreme offsets, then mode wraps back to raw
  task automatic test_offset_frames();
    offer_item(button_item(1'b0, 1'b0, 1'b1, 9'sd0, 9'sd0));
    offer_item(frame_item(9'sd59, 9'sd255));
    offer_item(frame_item(9'sd255, 9'sd0));
    offer_item(frame_item(OFFSCREEN, OFFSCREEN));
    offer_item(button_item(1'b0, 1'b0, 1'b1, OFFSCREEN, OFFSCREEN));
    offer_item(frame_item(9'sd0, 9'sd0));
  endtask

  task automatic test_random_mix();
    run_mix(items_sent + RANDOM_ITEMS);
  endtask

  // result side holds off while items keep coming, so the input backs up
  task automatic test_full_stall();
    hold_request = HOLD_CYCLES;
    run_mix(items_sent + HOLD_ITEMS);
  endtask

  // back to back on both sides
  task automatic test_flat_out();
    send_gaps = 1'b0;
    take_gaps = 1'b0;
    run_mix(items_sent + FLAT_ITEMS);
  endtask

  initial begin
    rst                    <= 1'b1;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= REQ_BUTTON;
    req_ch.trigger_pressed <= 1'b0;
    req_ch.calib_pressed   <= 1'b0;
    req_ch.mode_pressed    <= 1'b0;
    req_ch.raw_x           <= '0;
    req_ch.raw_y           <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_raw_frames();
    test_mapped_frames();
    test_calibration();
    test_offset_frames();
    test_random_mix();
    test_full_stall();
    test_flat_out();

    req_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("light_gun_calibrated_aim_top_test: clean");
    end else begin
      $display("light_gun_calibrated_aim_top_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/lgca_pkg.sv
design/lgca_if.sv
design/light_gun_calibrated_aim_top.sv
tb/sv/light_gun_calibrated_aim_top_test.sv
